// File: rtl/core/sli_pkg.sv
// Shared types, codes and constants of the sorted insertion list.
`default_nettype none

package sli_pkg;

    // Default list depth and fixed field widths
    localparam int CAPACITY_DEF = 16;
    localparam int ELEM_W       = 32;
    localparam int CNT_OUT_W    = 5;

    // Requested action of one input item
    typedef enum logic [1:0] {
        ACT_INSERT   = 2'd0,
        ACT_DEL_ONE  = 2'd1,
        ACT_DEL_ALL  = 2'd2,
        ACT_READ_OUT = 2'd3
    } action_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    // Operation applied to the entry cells in a given cycle
    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_ROTATE = 2'd3
    } op_t;

    // Controller to datapath command
    typedef struct packed {
        logic    load;
        op_t     op;
        logic    push;
        status_t status;
        logic    last;
    } sli_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
        logic full;
        logic match;
        logic empty;
        logic rd_last;
    } sli_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/sorted_list_insert_delete_unit.sv
// Top level: sorted insertion list of signed words, controller plus datapath.
// Insert and single delete: the action state pushes one result once the result register is free.
// Delete all: removes one match per cycle (one cell shift each), then pushes one result.
// Read out: one entry per cycle while results are taken, smallest first; a single result if empty.
// The next item is taken once the final result of the current one is registered.
// Reset clears count, controller and result valid; entry cells are not cleared.
`default_nettype none

module sorted_list_insert_delete_unit
    import sli_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [1:0]               s_action,
    input  wire logic signed [ELEM_W-1:0] s_value,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed [ELEM_W-1:0]      m_element,
    output logic [CNT_OUT_W-1:0]          m_entry_count,
    output logic [1:0]                    m_status,
    output logic                          m_last
);

    sli_cmd_t  cmd;
    sli_stat_t stat;

    sli_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .stat     (stat),
        .cmd      (cmd)
    );

    sli_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_value       (s_value),
        .cmd           (cmd),
        .stat          (stat),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_element     (m_element),
        .m_entry_count (m_entry_count),
        .m_status      (m_status),
        .m_last        (m_last)
    );

endmodule

`default_nettype wire

// File: rtl/core/sli_datapath.sv
// Datapath: entry cells, count, read-out counter and result register.
`default_nettype none

module sli_datapath
    import sli_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic signed [ELEM_W-1:0]    s_value,
    input  wire sli_cmd_t                    cmd,
    output sli_stat_t                        stat,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic signed [ELEM_W-1:0]         m_element,
    output logic [CNT_OUT_W-1:0]             m_entry_count,
    output logic [1:0]                       m_status,
    output logic                             m_last
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    logic signed [ELEM_W-1:0] ent_reg  [CAPACITY];
    logic signed [ELEM_W-1:0] ent_next [CAPACITY];
    logic signed [ELEM_W-1:0] value_reg;
    logic [CW-1:0]            count_reg, count_next;
    logic [IW-1:0]            rd_reg;

    logic [CAPACITY-1:0] valid, gt, eq, ge;

    logic                     m_valid_reg;
    logic signed [ELEM_W-1:0] m_element_reg;
    logic [CNT_OUT_W-1:0]     m_entry_count_reg;
    status_t                  m_status_reg;
    logic                     m_last_reg;

    // Compare every valid cell against the operand in parallel
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            valid[i] = CW'(i) < count_reg;
            gt[i]    = valid[i] && (value_reg < ent_reg[i]);
            eq[i]    = valid[i] && (ent_reg[i] == value_reg);
            ge[i]    = valid[i] && !(ent_reg[i] < value_reg);
        end
    end

    // Per-cell next value: shift up on insert, down on delete, rotate on read-out
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [ELEM_W-1:0] prev_val;
        logic                     prev_gt;
        logic signed [ELEM_W-1:0] succ_val;
        logic                     succ_valid;

        if (i == 0) begin : g_first
            assign prev_val = value_reg;
            assign prev_gt  = 1'b0;
        end else begin : g_mid
            assign prev_val = ent_reg[i-1];
            assign prev_gt  = gt[i-1];
        end

        if (i == CAPACITY - 1) begin : g_top
            assign succ_val   = ent_reg[i];
            assign succ_valid = 1'b0;
        end else begin : g_below
            assign succ_val   = ent_reg[i+1];
            assign succ_valid = valid[i+1];
        end

        always_comb begin
            ent_next[i] = ent_reg[i];
            unique case (cmd.op)
                OP_INSERT: begin
                    if (gt[i] || (CW'(i) == count_reg)) begin
                        ent_next[i] = prev_gt ? prev_val : value_reg;
                    end
                end
                OP_DELETE: begin
                    if (ge[i]) begin
                        ent_next[i] = succ_val;
                    end
                end
                OP_ROTATE: begin
                    if (CW'(i) == count_reg - CW'(1)) begin
                        ent_next[i] = ent_reg[0];
                    end else if (succ_valid) begin
                        ent_next[i] = succ_val;
                    end
                end
                default: ent_next[i] = ent_reg[i];
            endcase
        end

        always_ff @(posedge aclk) begin
            ent_reg[i] <= ent_next[i];
        end
    end

    // Update entry count
    always_comb begin
        unique case (cmd.op)
            OP_INSERT: count_next = count_reg + CW'(1);
            OP_DELETE: count_next = count_reg - CW'(1);
            default:   count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Latch operand and restart read-out position on transfer in
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            value_reg <= s_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_reg <= '0;
        end else if (cmd.load) begin
            rd_reg <= '0;
        end else if (cmd.op == OP_ROTATE) begin
            rd_reg <= rd_reg + IW'(1);
        end
    end

    // Result register: hold until transfer, load on push
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.push) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            m_element_reg     <= (cmd.op == OP_ROTATE) ? ent_reg[0] : '0;
            m_entry_count_reg <= CNT_OUT_W'(count_next);
            m_status_reg      <= cmd.status;
            m_last_reg        <= cmd.last;
        end
    end

    // Status back to the controller
    always_comb begin
        stat.out_free = !m_valid_reg || m_ready;
        stat.full     = count_reg >= CW'(CAPACITY);
        stat.match    = |eq;
        stat.empty    = count_reg == '0;
        stat.rd_last  = CW'(rd_reg) == count_reg - CW'(1);
    end

    assign m_valid       = m_valid_reg;
    assign m_element     = m_element_reg;
    assign m_entry_count = m_entry_count_reg;
    assign m_status      = m_status_reg;
    assign m_last        = m_last_reg;

endmodule

`default_nettype wire

// File: rtl/core/sli_ctrl.sv
// Controller: state machine that sequences each action over the datapath.
`default_nettype none

module sli_ctrl
    import sli_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_action,
    input  wire sli_stat_t  stat,
    output sli_cmd_t        cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_INS  = 5'b00010,
        S_DEL1 = 5'b00100,
        S_DALL = 5'b01000,
        S_READ = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   found_reg, found_next;

    // Next state and command decode
    always_comb begin
        state_next = state_reg;
        found_next = found_reg;
        cmd        = '{load: 1'b0, op: OP_NONE, push: 1'b0, status: ST_OK, last: 1'b0};
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    found_next = 1'b0;
                    unique case (action_t'(s_action))
                        ACT_INSERT:   state_next = S_INS;
                        ACT_DEL_ONE:  state_next = S_DEL1;
                        ACT_DEL_ALL:  state_next = S_DALL;
                        ACT_READ_OUT: state_next = S_READ;
                        default:      state_next = S_IDLE;
                    endcase
                end
            end
            S_INS: begin
                if (stat.out_free) begin
                    cmd.push = 1'b1;
                    cmd.last = 1'b1;
                    if (stat.full) begin
                        cmd.status = ST_FULL;
                    end else begin
                        cmd.op = OP_INSERT;
                    end
                    state_next = S_IDLE;
                end
            end
            S_DEL1: begin
                if (stat.out_free) begin
                    cmd.push = 1'b1;
                    cmd.last = 1'b1;
                    if (stat.match) begin
                        cmd.op = OP_DELETE;
                    end else begin
                        cmd.status = ST_NOT_FOUND;
                    end
                    state_next = S_IDLE;
                end
            end
            S_DALL: begin
                // Drop one match per cycle until none is left
                if (stat.match) begin
                    cmd.op     = OP_DELETE;
                    found_next = 1'b1;
                end else if (stat.out_free) begin
                    cmd.push   = 1'b1;
                    cmd.last   = 1'b1;
                    cmd.status = found_reg ? ST_OK : ST_NOT_FOUND;
                    state_next = S_IDLE;
                end
            end
            S_READ: begin
                if (stat.out_free) begin
                    cmd.push = 1'b1;
                    if (stat.empty) begin
                        cmd.status = ST_EMPTY;
                        cmd.last   = 1'b1;
                        state_next = S_IDLE;
                    end else begin
                        cmd.op   = OP_ROTATE;
                        cmd.last = stat.rd_last;
                        if (stat.rd_last) begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            found_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            found_reg <= found_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/sli_checker.sv
// Port-level checker for the sorted insertion list, bound to the top level.
`default_nettype none

module sli_checker
    import sli_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input wire logic                     aclk,
    input wire logic                     aresetn,
    input wire logic                     s_valid,
    input wire logic                     s_ready,
    input wire logic [1:0]               s_action,
    input wire logic signed [ELEM_W-1:0] s_value,
    input wire logic                     m_valid,
    input wire logic                     m_ready,
    input wire logic signed [ELEM_W-1:0] m_element,
    input wire logic [CNT_OUT_W-1:0]     m_entry_count,
    input wire logic [1:0]               m_status,
    input wire logic                     m_last
);

    // Stalled result holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_element) && $stable(m_last)
            && $stable(m_status) && $stable(m_entry_count))
        else $error("result changed while stalled");

    // A dropped insert reports a full list
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_FULL) |->
            m_last && (m_element == '0) && (m_entry_count == CNT_OUT_W'(CAPACITY)))
        else $error("full status with wrong fields");

    // An empty read-out is a single zero result
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_EMPTY) |->
            m_last && (m_element == '0) && (m_entry_count == '0))
        else $error("empty status with wrong fields");

    // Read-out streams without gaps and no new item enters mid-stream
    a_stream: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid && (m_status == ST_OK))
        else $error("read-out stream broken");

    a_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !s_ready)
        else $error("input taken during read-out");

endmodule

bind sorted_list_insert_delete_unit sli_checker #(.CAPACITY(CAPACITY)) u_sli_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_action      (s_action),
    .s_value       (s_value),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_element     (m_element),
    .m_entry_count (m_entry_count),
    .m_status      (m_status),
    .m_last        (m_last)
);

`default_nettype wire

// File: sim/tb_sorted_list_insert_delete_unit.sv
// Testbench for the sorted insertion list: directed and random requests checked by a scoreboard.
module tb_sorted_list_insert_delete_unit
    import sli_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH   = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 200;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = LIST_DEPTH + 8;

    typedef struct {
        logic signed [ELEM_W-1:0] element;
        logic [CNT_OUT_W-1:0]     entry_count;
        status_t                  status;
        logic                     last;
    } list_result_t;

    // Predict the list contents and the results of every accepted request
    class sorted_list_scoreboard;
        logic signed [ELEM_W-1:0] held[$];
        list_result_t             awaited[$];
        int errors;
        int requests;
        int results;
        int full_drops;
        int misses;
        int empty_reads;
        int full_reads;

        function void queue_result(logic signed [ELEM_W-1:0] el, status_t st, logic lst);
            list_result_t r;
            r.element     = el;
            r.entry_count = CNT_OUT_W'(held.size());
            r.status      = st;
            r.last        = lst;
            awaited.insert(awaited.size(), r);
        endfunction

        function void note_request(action_t act, logic signed [ELEM_W-1:0] val);
            int pos;
            bit found;
            logic signed [ELEM_W-1:0] kept[$];
            requests++;
            case (act)
                ACT_INSERT: begin
                    if (held.size() >= LIST_DEPTH) begin
                        full_drops++;
                        queue_result('0, ST_FULL, 1'b1);
                    end else begin
                        // equal values go after the ones already held
                        pos = held.size();
                        while (pos > 0 && val < held[pos-1]) pos--;
                        held.insert(pos, val);
                        queue_result('0, ST_OK, 1'b1);
                    end
                end
                ACT_DEL_ONE: begin
                    found = 1'b0;
                    for (int i = 0; i < held.size(); i++) begin
                        if (held[i] == val) begin
                            held.delete(i);
                            found = 1'b1;
                            break;
                        end
                    end
                    if (!found) misses++;
                    queue_result('0, found ? ST_OK : ST_NOT_FOUND, 1'b1);
                end
                ACT_DEL_ALL: begin
                    found = 1'b0;
                    foreach (held[i]) begin
                        if (held[i] == val) found = 1'b1;
                        else kept.insert(kept.size(), held[i]);
                    end
                    held = kept;
                    if (!found) misses++;
                    queue_result('0, found ? ST_OK : ST_NOT_FOUND, 1'b1);
                end
                default: begin
                    if (held.size() == 0) begin
                        empty_reads++;
                        queue_result('0, ST_EMPTY, 1'b1);
                    end else begin
                        if (held.size() == LIST_DEPTH) full_reads++;
                        foreach (held[i])
                            queue_result(held[i], ST_OK, i == held.size() - 1);
                    end
                end
            endcase
        endfunction

        function void check_result(logic signed [ELEM_W-1:0] el, logic [CNT_OUT_W-1:0] cnt,
                                   logic [1:0] st, logic lst);
            list_result_t exp;
            results++;
            if (awaited.size() == 0) begin
                $error("unexpected result: element %0d count %0d status %0d last %0d",
                       el, cnt, st, lst);
                errors++;
                return;
            end
            exp = awaited.pop_front();
            if (el !== exp.element) begin
                $error("element: expected %0d, got %0d", exp.element, el);
                errors++;
            end
            if (cnt !== exp.entry_count) begin
                $error("entry_count: expected %0d, got %0d", exp.entry_count, cnt);
                errors++;
            end
            if (st !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, st);
                errors++;
            end
            if (lst !== exp.last) begin
                $error("last: expected %0d, got %0d", exp.last, lst);
                errors++;
            end
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [1:0]               s_action;
    logic signed [ELEM_W-1:0] s_value;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [ELEM_W-1:0] m_element;
    logic [CNT_OUT_W-1:0]     m_entry_count;
    logic [1:0]               m_status;
    logic                     m_last;

    sorted_list_scoreboard sb = new();
    int  burst_left;
    bit  hold_request;
    int  idle_cycles;

    sorted_list_insert_delete_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_element     (m_element),
        .m_entry_count (m_entry_count),
        .m_status      (m_status),
        .m_last        (m_last)
    );

    // Generate a 10 ns clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Offer one request, wait for its transfer, then either keep the burst going or gap
    task automatic send_req(input action_t act, input logic signed [ELEM_W-1:0] val);
        s_action <= act;
        s_value  <= val;
        s_valid  <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(act, val);
        @(negedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
        end
    endtask

    // Mix extremes, a dense small range (for duplicates) and full-range values
    function automatic logic signed [ELEM_W-1:0] random_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 32'sh8000_0000;
        if (r == 1) return 32'sh7FFF_FFFF;
        if (r < 6)  return $signed(32'($urandom_range(0, 8))) - 4;
        return $signed($urandom);
    endfunction

    // Pick a random request; deletes usually target a value that is held
    task automatic random_req(input int insert_pct);
        int r;
        action_t act;
        logic signed [ELEM_W-1:0] val;
        r   = $urandom_range(0, 99);
        val = random_value();
        if (r < insert_pct) act = ACT_INSERT;
        else if (r < insert_pct + (100 - insert_pct) * 4 / 10) act = ACT_DEL_ONE;
        else if (r < insert_pct + (100 - insert_pct) * 6 / 10) act = ACT_DEL_ALL;
        else act = ACT_READ_OUT;
        if ((act == ACT_DEL_ONE || act == ACT_DEL_ALL) && sb.held.size() > 0
                && $urandom_range(0, 9) < 7)
            val = sb.held[$urandom_range(0, sb.held.size() - 1)];
        send_req(act, val);
    endtask

    // Check every result transfer
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_element, m_entry_count, m_status, m_last);
    end

    // Stall the result channel on changing patterns, with one long hold-off on request
    initial begin
        int mode;
        int span;
        int tick;
        m_ready = 1'b0;
        tick    = 0;
        @(posedge aresetn);
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 80);
            repeat (span) begin
                @(negedge aclk);
                tick++;
                if (hold_request) begin
                    m_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge aclk);
                    hold_request = 1'b0;
                end
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= (tick % 4 == 0);
                    default: m_ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // End the run if nothing moves for too long
    initial begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("tb_sorted_list_insert_delete_unit: FAIL");
        $finish;
    end

    // Reset, directed requests, random requests, drain
    initial begin
        int insert_pct;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_action     = ACT_INSERT;
        s_value      = '0;
        burst_left   = 0;
        hold_request = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty list: read-out and deletes that find nothing
        send_req(ACT_READ_OUT, 32'sh1234_5678);
        send_req(ACT_DEL_ONE, 5);
        send_req(ACT_DEL_ALL, 5);
        // extremes, duplicates, signed ordering
        send_req(ACT_INSERT, 32'sh7FFF_FFFF);
        send_req(ACT_INSERT, 32'sh8000_0000);
        send_req(ACT_INSERT, 0);
        send_req(ACT_INSERT, -1);
        send_req(ACT_INSERT, 0);
        send_req(ACT_INSERT, 0);
        send_req(ACT_READ_OUT, -1);
        send_req(ACT_DEL_ONE, 0);
        send_req(ACT_DEL_ALL, 0);
        send_req(ACT_DEL_ONE, 12345);
        send_req(ACT_DEL_ALL, 12345);
        send_req(ACT_READ_OUT, 0);
        // fill to capacity, then overflow and read the full list
        while (sb.held.size() < LIST_DEPTH) send_req(ACT_INSERT, random_value());
        send_req(ACT_INSERT, 7);
        send_req(ACT_READ_OUT, 32'shFFFF_FFFF);
        send_req(ACT_DEL_ALL, 32'sh8000_0000);

        // random phase in rounds with a changing fill bias
        hold_request = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 20 == 0) insert_pct = $urandom_range(25, 85);
            random_req(insert_pct);
        end

        s_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d requests and %0d results: %0d dropped inserts, %0d misses,",
                 sb.requests, sb.results, sb.full_drops, sb.misses);
        $display("  %0d empty read-outs, %0d full read-outs, %0d mismatches.",
                 sb.empty_reads, sb.full_reads, sb.errors);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("tb_sorted_list_insert_delete_unit: PASS");
        else
            $display("tb_sorted_list_insert_delete_unit: FAIL");
        $finish;
    end

endmodule
